/* rtl/core/itvw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itvw_pkg
// Shared constants, register codes and control/status types for the
// index-to-variable-length-word converter.
// ----------------------------------------------------------------------------
package itvw_pkg;

  // Default sizes
  localparam int ITVW_MAX_LEN        = 8;
  localparam int ITVW_ALPHABET_DEPTH = 256;

  // Field widths
  localparam int INDEX_W = 64;
  localparam int SLOT_W  = 8;
  localparam int CHAR_W  = 8;
  localparam int BASE_W  = 9;
  localparam int MLEN_W  = 4;
  localparam int POS_W   = 3;
  localparam int CFG_W   = 9;
  localparam int CFG_IDX_W = 1;

  // Register codes
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH  = 1'b1;

  // Register reset values
  localparam logic [BASE_W-1:0] BASE_RESET = 9'd62;
  localparam logic [MLEN_W-1:0] MLEN_RESET = 4'd8;

  // Controller -> datapath commands
  typedef struct packed {
    logic alpha_wr;      // store one alphabet entry
    logic load_idx;      // capture index, restart bound search
    logic mul_step;      // next power of the base
    logic add_step;      // next length bound
    logic sub_init;      // offset of the index inside its length class
    logic div_start;     // launch one digit division
    logic div_store;     // keep digit and quotient
    logic rd_issue;      // read alphabet for current digit
    logic out_load_char; // load a character beat
    logic out_load_oor;  // load the out-of-range beat
  } itvw_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic hit;        // index lies below the new bound
    logic at_max;     // new bound is the longest allowed
    logic div_done;   // divider finished
    logic last_digit; // digit just stored is the top one
    logic pos_zero;   // current emit position is the rightmost
    logic out_free;   // output register can take a beat
  } itvw_status_t;

endpackage
`default_nettype wire

/* rtl/core/itvw_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itvw_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module itvw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/itvw_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itvw_div
// Restoring divider, 64-bit dividend by 9-bit divisor, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module itvw_div
  import itvw_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [INDEX_W-1:0] dividend_i,
  input  wire logic [BASE_W-1:0]  divisor_i,
  output logic      [INDEX_W-1:0] quotient_o,
  output logic      [BASE_W-1:0]  remainder_o,
  output logic                    done_o
);

  localparam int CNT_W = $clog2(INDEX_W);

  logic [INDEX_W-1:0] dq_q;
  logic [BASE_W-1:0]  rem_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               busy_q;
  logic               done_q;

  logic [BASE_W:0] trial;
  logic            ge;
  logic [BASE_W:0] diff;

  assign trial = {rem_q, dq_q[INDEX_W-1]};
  assign ge    = trial >= {1'b0, divisor_i};
  assign diff  = trial - {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(INDEX_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      // shift in next dividend bit, subtract when it fits
      dq_q  <= {dq_q[INDEX_W-2:0], ge};
      rem_q <= ge ? diff[BASE_W-1:0] : trial[BASE_W-1:0];
    end
  end

  assign quotient_o  = dq_q;
  assign remainder_o = rem_q;
  assign done_o      = done_q;

endmodule
`default_nettype wire

/* rtl/core/itvw_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itvw_datapath
// Configuration registers, bound search, digit extraction, digit store,
// alphabet lookup and output register.
// ----------------------------------------------------------------------------
module itvw_datapath
  import itvw_pkg::*;
#(
  parameter int MAX_LEN        = ITVW_MAX_LEN,
  parameter int ALPHABET_DEPTH = ITVW_ALPHABET_DEPTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire itvw_cmd_t          cmd_i,
  output itvw_status_t            status_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]   cfg_wdata_i,
  input  wire logic [INDEX_W-1:0] index_i,
  input  wire logic [SLOT_W-1:0]  alphabet_slot_i,
  input  wire logic [CHAR_W-1:0]  alphabet_char_i,
  input  wire logic               out_stall_i,
  output logic                    out_valid_o,
  output logic      [CHAR_W-1:0]  character_o,
  output logic      [POS_W-1:0]   digit_position_o,
  output logic                    last_o,
  output logic                    out_of_range_o
);

  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int P_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int AW    = $clog2(ALPHABET_DEPTH);

  // configuration
  logic [BASE_W-1:0] symbol_base_q;
  logic [MLEN_W-1:0] max_length_q;
  logic [BASE_W-1:0] eff_base;
  logic [MLEN_W-1:0] eff_len4;
  logic [LEN_W-1:0]  eff_len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      symbol_base_q <= BASE_RESET;
      max_length_q  <= MLEN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SYMBOL_BASE: symbol_base_q <= cfg_wdata_i[BASE_W-1:0];
        REG_MAX_LENGTH:  max_length_q  <= cfg_wdata_i[MLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (symbol_base_q < BASE_W'(2)) begin
      eff_base = BASE_W'(2);
    end else if (symbol_base_q > BASE_W'(ALPHABET_DEPTH)) begin
      eff_base = BASE_W'(ALPHABET_DEPTH);
    end else begin
      eff_base = symbol_base_q;
    end
    if (max_length_q == '0) begin
      eff_len4 = MLEN_W'(1);
    end else if (max_length_q > MLEN_W'(MAX_LEN)) begin
      eff_len4 = MLEN_W'(MAX_LEN);
    end else begin
      eff_len4 = max_length_q;
    end
  end
  assign eff_len = LEN_W'(eff_len4);

  // bound search
  logic [INDEX_W-1:0] idx_q, pw_q, sum_q, work_q;
  logic [LEN_W-1:0]   len_q;
  logic [INDEX_W+BASE_W-1:0] prod;
  logic [INDEX_W:0]   sum_ext;
  logic [INDEX_W-1:0] new_bound;
  logic [LEN_W-1:0]   len_next;

  assign prod      = {{BASE_W{1'b0}}, pw_q} * {{INDEX_W{1'b0}}, eff_base};
  assign sum_ext   = {1'b0, sum_q} + {1'b0, pw_q};
  assign new_bound = sum_ext[INDEX_W] ? '1 : sum_ext[INDEX_W-1:0];
  assign len_next  = len_q + 1'b1;

  // digits
  logic [CHAR_W-1:0] digits_q [MAX_LEN];
  logic [P_W-1:0]    k_q, pos_q;
  logic [LEN_W:0]    k_plus;
  logic [INDEX_W-1:0] quot;
  logic [BASE_W-1:0]  rem;
  logic               div_done;

  assign k_plus = (LEN_W + 1)'(k_q) + 1'b1;

  itvw_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (work_q),
    .divisor_i   (eff_base),
    .quotient_o  (quot),
    .remainder_o (rem),
    .done_o      (div_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      k_q   <= '0;
      pos_q <= '0;
    end else begin
      if (cmd_i.load_idx) begin
        len_q <= '0;
      end else if (cmd_i.add_step) begin
        len_q <= len_next;
      end
      if (cmd_i.sub_init) begin
        k_q <= '0;
      end else if (cmd_i.div_store) begin
        k_q <= k_q + 1'b1;
      end
      if (cmd_i.div_store && status_o.last_digit) begin
        pos_q <= P_W'(len_q - 1'b1);
      end else if (cmd_i.out_load_char) begin
        pos_q <= pos_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_idx) begin
      idx_q <= index_i;
      pw_q  <= INDEX_W'(1);
      sum_q <= '0;
    end
    if (cmd_i.mul_step) begin
      // saturate the power at all ones
      pw_q <= (prod[INDEX_W+BASE_W-1:INDEX_W] != '0) ? '1 : prod[INDEX_W-1:0];
    end
    if (cmd_i.add_step && !status_o.hit) begin
      sum_q <= new_bound;
    end
    if (cmd_i.sub_init) begin
      work_q <= idx_q - sum_q;
    end else if (cmd_i.div_store) begin
      work_q <= quot;
    end
    if (cmd_i.div_store) begin
      digits_q[k_q] <= rem[CHAR_W-1:0];
    end
  end

  // alphabet
  logic              ram_we;
  logic [CHAR_W-1:0] ram_rdata;
  logic [CHAR_W-1:0] cur_digit;

  assign ram_we    = cmd_i.alpha_wr && ({1'b0, alphabet_slot_i} < (SLOT_W + 1)'(ALPHABET_DEPTH));
  assign cur_digit = digits_q[pos_q];

  itvw_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (ALPHABET_DEPTH)
  ) u_alphabet (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (alphabet_slot_i[AW-1:0]),
    .wdata_i (alphabet_char_i),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (cur_digit[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // output register
  logic             out_valid_q;
  logic [P_W+2:0]   pos_ext;

  assign pos_ext = {3'b000, pos_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load_char || cmd_i.out_load_oor) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load_char) begin
      character_o      <= ram_rdata;
      digit_position_o <= pos_ext[POS_W-1:0];
      last_o           <= (pos_q == '0);
      out_of_range_o   <= 1'b0;
    end else if (cmd_i.out_load_oor) begin
      character_o      <= '0;
      digit_position_o <= '0;
      last_o           <= 1'b1;
      out_of_range_o   <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    status_o.hit        = idx_q < new_bound;
    status_o.at_max     = len_next == eff_len;
    status_o.div_done   = div_done;
    status_o.last_digit = k_plus == (LEN_W + 1)'(len_q);
    status_o.pos_zero   = pos_q == '0;
    status_o.out_free   = !out_valid_q || !out_stall_i;
  end

endmodule
`default_nettype wire

/* rtl/core/itvw_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itvw_ctrl
// Sequencer: alphabet writes; bound search, digit divisions, then character emission or an out-of-range beat.
// ----------------------------------------------------------------------------
module itvw_ctrl
  import itvw_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  input  wire logic         func_i,
  output logic              in_stall_o,
  output itvw_cmd_t         cmd_o,
  input  wire itvw_status_t status_i
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_MUL      = 4'd1;
  localparam logic [3:0] S_ADD      = 4'd2;
  localparam logic [3:0] S_SUB      = 4'd3;
  localparam logic [3:0] S_DIV_GO   = 4'd4;
  localparam logic [3:0] S_DIV_RUN  = 4'd5;
  localparam logic [3:0] S_EMIT_RD  = 4'd6;
  localparam logic [3:0] S_EMIT_LD  = 4'd7;
  localparam logic [3:0] S_OOR      = 4'd8;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (func_i) begin
            cmd_o.load_idx = 1'b1;
            state_d        = S_MUL;
          end else begin
            cmd_o.alpha_wr = 1'b1;
          end
        end
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        state_d        = S_ADD;
      end
      S_ADD: begin
        cmd_o.add_step = 1'b1;
        if (status_i.hit) begin
          state_d = S_SUB;
        end else if (status_i.at_max) begin
          state_d = S_OOR;
        end else begin
          state_d = S_MUL;
        end
      end
      S_SUB: begin
        cmd_o.sub_init = 1'b1;
        state_d        = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        if (status_i.div_done) begin
          cmd_o.div_store = 1'b1;
          state_d = status_i.last_digit ? S_EMIT_RD : S_DIV_GO;
        end
      end
      S_EMIT_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (status_i.out_free) begin
          cmd_o.out_load_char = 1'b1;
          state_d = status_i.pos_zero ? S_IDLE : S_EMIT_RD;
        end
      end
      S_OOR: begin
        if (status_i.out_free) begin
          cmd_o.out_load_oor = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/index_to_variable_length_word.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// index_to_variable_length_word
// Converts a 64-bit index into a variable-length word over a loaded alphabet.
// ----------------------------------------------------------------------------
// Sequence: a load beat writes one alphabet entry. A convert beat of word length L
//   runs a bound search (S_MUL, S_ADD per length), one division per digit
//   (S_DIV_GO, S_DIV_RUN) and emission (S_EMIT_RD, S_EMIT_LD per character).
// Throughput: one item at a time; the bit-serial divider, run once per digit,
//   sets the rate. An out-of-range index ends after the bound search with one beat.
// Reset: asynchronous, active low; base 62, max length 8, alphabet undefined.
// ----------------------------------------------------------------------------
module index_to_variable_length_word
  import itvw_pkg::*;
#(
  parameter int MAX_LEN        = ITVW_MAX_LEN,
  parameter int ALPHABET_DEPTH = ITVW_ALPHABET_DEPTH
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration write port
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  // input channel
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 func_i,
  input  wire logic [INDEX_W-1:0]   index_i,
  input  wire logic [SLOT_W-1:0]    alphabet_slot_i,
  input  wire logic [CHAR_W-1:0]    alphabet_char_i,
  // output channel
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic      [CHAR_W-1:0]    character_o,
  output logic      [POS_W-1:0]     digit_position_o,
  output logic                      last_o,
  output logic                      out_of_range_o
);

  // The controller walks the length classes (power, then bound, one of
  // each per step), launches one division per digit from least to most
  // significant, then reads the digits back top-down through the alphabet.
  itvw_cmd_t    cmd;
  itvw_status_t status;

  itvw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  // The datapath holds configuration, bounds, digit store, alphabet RAM and
  // the output register; a finished beat waits there while the next item
  // may already be taken.
  itvw_datapath #(
    .MAX_LEN        (MAX_LEN),
    .ALPHABET_DEPTH (ALPHABET_DEPTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .index_i          (index_i),
    .alphabet_slot_i  (alphabet_slot_i),
    .alphabet_char_i  (alphabet_char_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .character_o      (character_o),
    .digit_position_o (digit_position_o),
    .last_o           (last_o),
    .out_of_range_o   (out_of_range_o)
  );

endmodule
`default_nettype wire

/* rtl/core/itvw_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itvw_checker
// Port-level checks for the index-to-variable-length-word converter.
// ----------------------------------------------------------------------------
module itvw_checker
  import itvw_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [CHAR_W-1:0] character_o,
  input wire logic [POS_W-1:0]  digit_position_o,
  input wire logic              last_o,
  input wire logic              out_of_range_o
);

  // out-of-range beat is a single, blank, final beat
  a_oor_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |->
      last_o && digit_position_o == '0 && character_o == '0)
    else $error("out-of-range beat malformed");

  // only the rightmost character closes a word
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> digit_position_o == '0)
    else $error("last beat not at position zero");

  // while a word is still being emitted, hold off new items
  a_busy_mid_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |-> in_stall_o)
    else $error("input accepted in the middle of a word");

  // a stalled beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(character_o) && $stable(digit_position_o)
      && $stable(last_o) && $stable(out_of_range_o))
    else $error("stalled output beat changed");

endmodule

bind index_to_variable_length_word itvw_checker u_itvw_checker (.*);
`default_nettype wire
